// ----- sv/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared constants and types for the heading steering controller.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_STEER_GAIN   = 1'b0,
    CFG_REVERSE_MODE = 1'b1
  } cfg_idx_t;

  localparam logic [15:0] STEER_GAIN_RST = 16'd6144;

  // Compass geometry in tenths of a degree.
  localparam logic [11:0] HEADING_FULL   = 12'd3600;
  localparam logic [11:0] HEADING_HALF   = 12'd1800;
  localparam logic [11:0] HEADING_HALF_M = 12'd1799;

  // Servo pulse limits.
  localparam logic [11:0] PW_MID  = 12'd2765;
  localparam logic [10:0] PW_SPAN = 11'd1106;

  // A gain*error product at or above this gives a correction of the full span.
  localparam logic [26:0] SAT_PRODUCT = 27'd1106000;

  // Reciprocal constants: x/1000 = (x*DIV1000_RECIP) >> 31 for x < 2^21,
  // e/18 = (e*DIV18_RECIP) >> 15 for e <= 1800,
  // d*100/1106 = (d*SPCT_RECIP) >> 20 for d <= 1106.
  localparam logic [21:0] DIV1000_RECIP = 22'd2147484;
  localparam logic [10:0] DIV18_RECIP   = 11'd1821;
  localparam logic [16:0] SPCT_RECIP    = 17'd94808;

  // Heading error and turn side of one heading pair.
  typedef struct packed {
    logic [10:0] err;
    logic        turn_pos;
  } err_info_t;

endpackage

// ----- sv/hsc_err_dir.sv -----
// ----------------------------------------------------------------------------
// hsc_err_dir
// Folds both headings onto the compass, forms the absolute error (at most a
// half turn) and picks the turn side from the half circle split at the target.
// ----------------------------------------------------------------------------
module hsc_err_dir (
  input  logic [11:0]       cur_raw,
  input  logic [11:0]       tgt_raw,
  output hsc_pkg::err_info_t info
);
  import hsc_pkg::*;

  logic [11:0] cur_w;
  logic [11:0] tgt_w;
  logic [11:0] abs_diff;
  logic [11:0] err_w;
  logic        pos_w;

  always_comb begin
    cur_w    = (cur_raw >= HEADING_FULL) ? cur_raw - HEADING_FULL : cur_raw;
    tgt_w    = (tgt_raw >= HEADING_FULL) ? tgt_raw - HEADING_FULL : tgt_raw;
    abs_diff = (cur_w >= tgt_w) ? cur_w - tgt_w : tgt_w - cur_w;
    err_w    = (abs_diff > HEADING_HALF) ? HEADING_FULL - abs_diff : abs_diff;

    if (tgt_w > HEADING_HALF_M) begin
      pos_w = (cur_w < tgt_w) && (cur_w > tgt_w - HEADING_HALF);
    end else begin
      pos_w = ({1'b0, cur_w} > ({1'b0, tgt_w} + {1'b0, HEADING_HALF})) ||
              (cur_w < tgt_w);
    end

    info.err      = err_w[10:0];
    info.turn_pos = pos_w;
  end

endmodule

// ----- sv/heading_steering_controller_unit.sv -----
// ----------------------------------------------------------------------------
// heading_steering_controller_unit
// Proportional steering toward a compass heading: servo pulse, PWM compare
// word and signed error and steering percentages for each heading pair.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------
//  in_      | input     | in_valid / in_ready   | current and target heading
//  out_     | output    | out_valid / out_ready | pulse, compare word, percents
//  cfg_     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One beat per cycle is accepted unless a stall backs up to the input; a result
// passes input register, gain product, divide by 1000 and output register.
// Each stage holds its beat while the next one is full and stalled, so a stall
// on the output backs up through the stages; bubbles are squeezed out.
// Reset clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module heading_steering_controller_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       in_current_heading,
  input  logic [11:0]       in_target_heading,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       out_steer_pulse,
  output logic [15:0]       out_compare_word,
  output logic signed [7:0] out_heading_error_pct,
  output logic signed [7:0] out_steer_pct,
  input  logic              cfg_we,
  input  hsc_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import hsc_pkg::*;

  // Configuration.
  logic [15:0] steer_gain_r;
  logic        reverse_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_gain_r   <= STEER_GAIN_RST;
      reverse_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEER_GAIN:   steer_gain_r   <= cfg_wdata;
        CFG_REVERSE_MODE: reverse_mode_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Stage valid bits and load enables.
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4      = !v4_r || out_ready;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // Stage 1: input register.
  logic [11:0] cur_r, tgt_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      cur_r <= in_current_heading;
      tgt_r <= in_target_heading;
    end
  end

  err_info_t   info;
  logic [26:0] prod_nxt;
  logic [21:0] herr_prod;

  hsc_err_dir u_err_dir (
    .cur_raw (cur_r),
    .tgt_raw (tgt_r),
    .info    (info)
  );

  assign prod_nxt  = 27'(steer_gain_r) * 27'(info.err);
  assign herr_prod = 22'(info.err) * 22'(DIV18_RECIP);

  // Stage 2: gain product, turn side and error magnitude in percent.
  logic [26:0] prod_r;
  logic        pos2_r;
  logic [6:0]  herr2_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      prod_r  <= prod_nxt;
      pos2_r  <= info.turn_pos ^ reverse_mode_r;
      herr2_r <= herr_prod[21:15];
    end
  end

  // A product past the saturation point pins the correction at the full span,
  // so only products below 2^21 go through the reciprocal.
  logic [42:0] q_prod;
  logic [10:0] delta_nxt;

  assign q_prod    = 43'(prod_r[20:0]) * 43'(DIV1000_RECIP);
  assign delta_nxt = (prod_r >= SAT_PRODUCT) ? PW_SPAN : q_prod[41:31];

  // Stage 3: clamped correction.
  logic [10:0] delta_r;
  logic        pos3_r;
  logic [6:0]  herr3_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      delta_r <= delta_nxt;
      pos3_r  <= pos2_r;
      herr3_r <= herr2_r;
    end
  end

  logic [11:0]       pulse_nxt;
  logic [27:0]       spct_prod;
  logic [7:0]        spct_mag;
  logic [7:0]        herr_mag;
  logic signed [7:0] spct_nxt;
  logic signed [7:0] herr_nxt;

  always_comb begin
    pulse_nxt = pos3_r ? PW_MID + 12'(delta_r) : PW_MID - 12'(delta_r);
    spct_prod = 28'(delta_r) * 28'(SPCT_RECIP);
    spct_mag  = {1'b0, spct_prod[26:20]};
    herr_mag  = {1'b0, herr3_r};
    spct_nxt  = pos3_r ? $signed(spct_mag) : -$signed(spct_mag);
    // The error percent takes a minus sign only when the pulse is above center.
    herr_nxt  = (pos3_r && (delta_r != 11'd0)) ? -$signed(herr_mag) : $signed(herr_mag);
  end

  // Stage 4: output register.
  logic [11:0]       pulse_r;
  logic [15:0]       cmp_r;
  logic signed [7:0] herr_pct_r;
  logic signed [7:0] spct_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      pulse_r    <= pulse_nxt;
      cmp_r      <= 16'hFFFF - {4'b0, pulse_nxt};
      herr_pct_r <= herr_nxt;
      spct_r     <= spct_nxt;
    end
  end

  assign out_valid             = v4_r;
  assign out_steer_pulse       = pulse_r;
  assign out_compare_word      = cmp_r;
  assign out_heading_error_pct = herr_pct_r;
  assign out_steer_pct         = spct_r;

endmodule

// ----- sv/hsc_checker.sv -----
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks on the result channel of the steering controller.
// ----------------------------------------------------------------------------
module hsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [11:0]       out_steer_pulse,
  input logic [15:0]       out_compare_word,
  input logic signed [7:0] out_heading_error_pct,
  input logic signed [7:0] out_steer_pct
);

  // No result beat may be left over from before reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_steer_pulse) && $stable(out_steer_pct))
    else $error("stalled result beat changed");

  a_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_compare_word == (16'hFFFF - {4'b0, out_steer_pulse}))
    else $error("compare word does not match pulse");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steer_pulse >= 12'd1659) && (out_steer_pulse <= 12'd3871))
    else $error("steering pulse outside servo limits");

  // Signs of both percentages follow the side of center the pulse is on.
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_steer_pulse > 12'd2765) && (out_steer_pct >= 0) &&
       (out_heading_error_pct <= 0)) ||
      ((out_steer_pulse <= 12'd2765) && (out_steer_pct <= 0) &&
       (out_heading_error_pct >= 0)))
    else $error("percent signs disagree with pulse");

endmodule

bind heading_steering_controller_unit hsc_checker u_hsc_checker (.*);
